// ===== hdl/mss_pkg.sv =====
// mss_pkg: shared constants, types and the elaboration-time cosine table builder
// for the maraca shaker synth. no dependencies; imported by maraca_shaker_synth.
package mss_pkg;

	// audio and table sizing
	localparam int SAMPLE_WIDTH      = 24;
	localparam int COS_TABLE_ENTRIES = 1024;
	localparam int COS_IDX_W         = $clog2(COS_TABLE_ENTRIES);
	localparam int PHASE_W           = 24;
	localparam int GROW_W            = 18;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_RES_COEFF_A1     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RES_COEFF_A2     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLLISION_PROB   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_DECAY     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SOUND_DECAY      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BEAN_GAIN        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SHAKE_PHASE_STEP = 3'd6;

	localparam logic signed [17:0] RST_RES_COEFF_A1     = -18'sd112985;
	localparam logic [15:0]        RST_RES_COEFF_A2     = 16'd60397;
	localparam logic [15:0]        RST_COLLISION_PROB   = 16'd4096;
	localparam logic [15:0]        RST_SYSTEM_DECAY     = 16'd65470;
	localparam logic [15:0]        RST_SOUND_DECAY      = 16'd62259;
	localparam logic [15:0]        RST_BEAN_GAIN        = 16'd7680;
	localparam logic [PHASE_W-1:0] RST_SHAKE_PHASE_STEP = 24'd7609;

	// output scaling: floor(d * 16 / 125) by reciprocal multiply
	// magnitude of d is clamped where the sample saturates anyway
	localparam int DIFF_LIM_W = (SAMPLE_WIDTH + 2 < 32) ? SAMPLE_WIDTH + 2 : 32;
	localparam int DIV_N_W    = DIFF_LIM_W + 5;
	localparam int DIV_SHIFT  = DIV_N_W + 7;
	localparam int DIV_Q_W    = SAMPLE_WIDTH + 1;
	localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_SHIFT) + 64'd124) / 64'd125;
	localparam logic [32:0] MAG_LIM   = 33'((64'd1 << DIFF_LIM_W) - 64'd1);

	// shared multiplier widths
	localparam int MUL_A_W = (DIV_N_W + 2 > 33) ? DIV_N_W + 2 : 33;
	localparam int MUL_B_W = (DIV_N_W + 1 > 19) ? DIV_N_W + 1 : 19;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Q30 angle constants
	localparam logic [63:0] Q30_ONE           = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30       = 64'd1686629713;
	localparam logic [63:0] PI_Q30            = 64'd3373259426;
	localparam logic [63:0] THREE_HALF_PI_Q30 = 64'd5059889139;
	localparam logic [63:0] TWO_PI_Q30        = 64'd6746518852;

	typedef logic [GROW_W-1:0] grow_word_t;
	typedef grow_word_t grow_table_t [COS_TABLE_ENTRIES];

	typedef enum logic [13:0] {
		ST_IDLE  = 14'h0001,
		ST_PHASE = 14'h0002,
		ST_EADD  = 14'h0004,
		ST_EMUL  = 14'h0008,
		ST_GMUL  = 14'h0010,
		ST_LADD  = 14'h0020,
		ST_XMUL  = 14'h0040,
		ST_DMUL  = 14'h0080,
		ST_A1MUL = 14'h0100,
		ST_A2MUL = 14'h0200,
		ST_YSUM  = 14'h0400,
		ST_DIFF  = 14'h0800,
		ST_QMUL  = 14'h1000,
		ST_OUT   = 14'h2000
	} mss_state_t;

	// first-quadrant cosine, taylor series by horner in Q30, rounded to Q16
	function automatic logic [16:0] cos_quadrant(input logic [63:0] th);
		logic [63:0] t2;
		logic [63:0] h;
		logic [63:0] p;
		logic [63:0] h_rnd;
		t2 = (th * th) >> 30;
		h  = Q30_ONE;
		for (int n = 7; n >= 1; n--) begin
			p = ((t2 * h) >> 30) / 64'((2 * n - 1) * (2 * n));
			h = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
		end
		h_rnd = (h + 64'd8192) >> 14;
		return h_rnd[16:0];
	endfunction

	// energy growth table: 65536 - cos(2*pi*k/N) in Q16
	function automatic grow_table_t build_grow_table();
		grow_table_t tab;
		logic [63:0] th;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			th = (TWO_PI_Q30 * 64'(k)) / 64'(COS_TABLE_ENTRIES);
			if (th <= HALF_PI_Q30)
				tab[k] = GROW_W'(18'd65536 - 18'(cos_quadrant(th)));
			else if (th <= PI_Q30)
				tab[k] = GROW_W'(18'd65536 + 18'(cos_quadrant(PI_Q30 - th)));
			else if (th <= THREE_HALF_PI_Q30)
				tab[k] = GROW_W'(18'd65536 + 18'(cos_quadrant(th - PI_Q30)));
			else
				tab[k] = GROW_W'(18'd65536 - 18'(cos_quadrant(TWO_PI_Q30 - th)));
		end
		return tab;
	endfunction

endpackage

// ===== hdl/maraca_shaker_synth.sv =====
// maraca_shaker_synth: fixed-point shaker (maraca) sound model, one sample per item.
// depends on mss_pkg for constants, the state encoding and the cosine table.
// One input item is one audio tick and yields one output sample. An item is
// taken only when the sequencer is idle and then steps through the states
// ST_PHASE to ST_OUT before a new item is taken. The sequence length is set
// by the single shared 33x32 signed multiplier, which is used seven times per
// item (energy decay, collision gain, noise drive, level decay, two resonator
// taps, and the reciprocal multiply that scales the output by 16/125), with a
// product register between uses. The finished sample sits in an output
// register, so the next item is accepted while the previous sample still waits
// to be taken; the sequence only holds in its last step if that register is
// still full. The cosine table (1024 entries) is a ROM built at elaboration
// and read through a registered port. Configuration writes are taken in any
// cycle (cfg_ready is always high) but must only be issued while the block is
// idle; writes to an index beyond the register list are ignored. No clearing
// pass is needed after reset. shake_start on an item clears the shake and
// resonator state before that tick is computed.
module maraca_shaker_synth
	import mss_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	// tick input channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           shake_start,
	input  logic [15:0]                    collision_draw,
	input  logic signed [15:0]             noise_draw,
	// sample output channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample
);

	localparam grow_table_t GROW_TABLE = build_grow_table();

	localparam logic [DIV_Q_W-1:0] Q_POS_MAX = DIV_Q_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
	localparam logic [DIV_Q_W-1:0] Q_NEG_MAX = DIV_Q_W'(64'd1 << (SAMPLE_WIDTH - 1));
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};

	// configuration registers
	logic signed [17:0]  res_coeff_a1_q;
	logic [15:0]         res_coeff_a2_q;
	logic [15:0]         collision_prob_q;
	logic [15:0]         system_decay_q;
	logic [15:0]         sound_decay_q;
	logic [15:0]         bean_gain_q;
	logic [PHASE_W-1:0]  shake_phase_step_q;

	// model state
	logic [PHASE_W-1:0]  shake_phase_q;
	logic                shake_done_q;
	logic [31:0]         shake_energy_q;
	logic [31:0]         sound_level_q;
	logic signed [31:0]  y0_q;
	logic signed [31:0]  y1_q;

	// per-item working registers
	mss_state_t          state_q;
	logic                collide_q;
	logic signed [15:0]  noise_q;
	logic                grow_en_q;
	grow_word_t          grow_q;
	logic signed [25:0]  x_q;
	logic signed [35:0]  acc_q;
	logic [DIV_N_W-1:0]  div_n_q;
	logic                div_neg_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic                out_valid_q;

	// combinational
	logic                in_take;
	logic                out_load;
	logic [PHASE_W:0]    phase_sum;
	logic [PHASE_W+COS_IDX_W-1:0] idx_prod;
	logic [COS_IDX_W-1:0] cos_idx;
	logic [32:0]         energy_sum;
	logic [36:0]         level_sum;
	logic                mul_en;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [33:0]  a1_term;
	logic signed [32:0]  a2_term;
	logic signed [35:0]  y_full;
	logic signed [31:0]  y_sat;
	logic signed [32:0]  diff;
	logic [32:0]         diff_mag;
	logic [DIFF_LIM_W-1:0] diff_clamp;
	logic [DIV_Q_W-1:0]  quot;
	logic [DIV_Q_W-1:0]  quot_neg;
	logic [SAMPLE_WIDTH-1:0] sample_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_coeff_a1_q     <= RST_RES_COEFF_A1;
			res_coeff_a2_q     <= RST_RES_COEFF_A2;
			collision_prob_q   <= RST_COLLISION_PROB;
			system_decay_q     <= RST_SYSTEM_DECAY;
			sound_decay_q      <= RST_SOUND_DECAY;
			bean_gain_q        <= RST_BEAN_GAIN;
			shake_phase_step_q <= RST_SHAKE_PHASE_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_RES_COEFF_A1:     res_coeff_a1_q     <= $signed(cfg_data[17:0]);
				REG_RES_COEFF_A2:     res_coeff_a2_q     <= cfg_data[15:0];
				REG_COLLISION_PROB:   collision_prob_q   <= cfg_data[15:0];
				REG_SYSTEM_DECAY:     system_decay_q     <= cfg_data[15:0];
				REG_SOUND_DECAY:      sound_decay_q      <= cfg_data[15:0];
				REG_BEAN_GAIN:        bean_gain_q        <= cfg_data[15:0];
				REG_SHAKE_PHASE_STEP: shake_phase_step_q <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	// phase advance and cosine table index from the new phase
	always_comb begin
		phase_sum = {1'b0, shake_phase_q} + {1'b0, shake_phase_step_q};
		idx_prod  = (PHASE_W + COS_IDX_W)'(phase_sum[PHASE_W-1:0])
			* (PHASE_W + COS_IDX_W)'(COS_TABLE_ENTRIES);
		cos_idx   = idx_prod[PHASE_W+COS_IDX_W-1:PHASE_W];
	end

	// saturating adds
	assign energy_sum = {1'b0, shake_energy_q} + 33'(grow_q);
	assign level_sum  = 37'(sound_level_q) + 37'(prod_q[47:12]);

	// resonator terms, floor by arithmetic shift
	assign a1_term = $signed(prod_q[49:16]);
	assign a2_term = $signed(prod_q[48:16]);
	assign y_full  = acc_q - 36'(a2_term);

	always_comb begin
		if (y_full > 36'sd2147483647)
			y_sat = 32'sh7fffffff;
		else if (y_full < -36'sd2147483648)
			y_sat = 32'sh80000000;
		else
			y_sat = y_full[31:0];
	end

	// output difference, clamped where the sample saturates anyway
	always_comb begin
		diff     = 33'(y0_q) - 33'(y1_q);
		diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
		if (diff_mag > MAG_LIM)
			diff_clamp = MAG_LIM[DIFF_LIM_W-1:0];
		else
			diff_clamp = diff_mag[DIFF_LIM_W-1:0];
	end

	// quotient from the reciprocal product, then sign and saturate
	always_comb begin
		quot     = prod_q[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT];
		quot_neg = DIV_Q_W'(0) - quot;
		if (div_neg_q) begin
			if (quot >= Q_NEG_MAX)
				sample_next = SAMPLE_MIN;
			else
				sample_next = quot_neg[SAMPLE_WIDTH-1:0];
		end else begin
			if (quot > Q_POS_MAX)
				sample_next = SAMPLE_MAX;
			else
				sample_next = quot[SAMPLE_WIDTH-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_EMUL: begin
				mul_a = MUL_A_W'({1'b0, shake_energy_q});
				mul_b = MUL_B_W'({1'b0, system_decay_q});
			end
			ST_GMUL: begin
				mul_a = MUL_A_W'({1'b0, prod_q[47:16]});
				mul_b = MUL_B_W'({1'b0, bean_gain_q});
			end
			ST_XMUL: begin
				mul_a = MUL_A_W'({1'b0, sound_level_q});
				mul_b = MUL_B_W'(noise_q);
			end
			ST_DMUL: begin
				mul_a = MUL_A_W'({1'b0, sound_level_q});
				mul_b = MUL_B_W'({1'b0, sound_decay_q});
			end
			ST_A1MUL: begin
				mul_a = MUL_A_W'(y0_q);
				mul_b = MUL_B_W'(res_coeff_a1_q);
			end
			ST_A2MUL: begin
				mul_a = MUL_A_W'(y1_q);
				mul_b = MUL_B_W'({1'b0, res_coeff_a2_q});
			end
			ST_QMUL: begin
				mul_a = MUL_A_W'(DIV_RECIP);
				mul_b = MUL_B_W'({1'b0, div_n_q});
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_a * mul_b;
	end

	// growth table rom, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_PHASE)
			grow_q <= GROW_TABLE[cos_idx];
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			collide_q <= (collision_draw < collision_prob_q);
			noise_q   <= noise_draw;
		end
		if (state_q == ST_DMUL)
			x_q <= $signed(prod_q[48:23]);
		if (state_q == ST_A2MUL)
			acc_q <= 36'(x_q) - 36'(a1_term);
		if (state_q == ST_DIFF) begin
			div_neg_q <= diff[32];
			div_n_q   <= DIV_N_W'({diff_clamp, 4'b0000})
				+ (diff[32] ? DIV_N_W'(124) : DIV_N_W'(0));
		end
		if (out_load)
			sample_q <= sample_next;
	end

	// sequencer and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			shake_phase_q  <= '0;
			shake_done_q   <= 1'b0;
			shake_energy_q <= '0;
			sound_level_q  <= '0;
			y0_q           <= '0;
			y1_q           <= '0;
			grow_en_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// a new sample fills the output register, a take empties it
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						// restart clears the state before this tick
						if (shake_start) begin
							shake_phase_q  <= '0;
							shake_done_q   <= 1'b0;
							shake_energy_q <= '0;
							sound_level_q  <= '0;
							y0_q           <= '0;
							y1_q           <= '0;
						end
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					grow_en_q <= !shake_done_q;
					if (!shake_done_q) begin
						shake_phase_q <= phase_sum[PHASE_W-1:0];
						shake_done_q  <= phase_sum[PHASE_W];
					end
					state_q <= ST_EADD;
				end
				ST_EADD: begin
					if (grow_en_q)
						shake_energy_q <= energy_sum[32] ? 32'hffffffff : energy_sum[31:0];
					state_q <= ST_EMUL;
				end
				ST_EMUL: state_q <= ST_GMUL;
				ST_GMUL: begin
					// decayed energy, also fed to the gain multiply
					shake_energy_q <= prod_q[47:16];
					state_q        <= ST_LADD;
				end
				ST_LADD: begin
					if (collide_q)
						sound_level_q <= (level_sum[36:32] != 5'd0) ? 32'hffffffff
							: level_sum[31:0];
					state_q <= ST_XMUL;
				end
				ST_XMUL: state_q <= ST_DMUL;
				ST_DMUL: state_q <= ST_A1MUL;
				ST_A1MUL: begin
					sound_level_q <= prod_q[47:16];
					state_q       <= ST_A2MUL;
				end
				ST_A2MUL: state_q <= ST_YSUM;
				ST_YSUM: begin
					y1_q    <= y0_q;
					y0_q    <= y_sat;
					state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_QMUL;
				ST_QMUL: state_q <= ST_OUT;
				ST_OUT: begin
					// wait here only while the previous sample is still unread
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// fixed sequence length from accept to the output step
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##13 (state_q == ST_OUT))
		else $error("sequence did not reach the output step on time");

	// a finished shake stays finished until a restart
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		shake_done_q && !(in_valid && in_ready && shake_start) |=> shake_done_q)
		else $error("shake done flag dropped without restart");

	// the phase no longer moves once the shake has ended
	a_phase_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		shake_done_q && (state_q == ST_PHASE) |=> $stable(shake_phase_q))
		else $error("phase advanced after the shake ended");

endmodule
